/* rtl/ndmr_pkg.sv */
package ndmr_pkg;

    // Header of a short MIME record: flags, type length, payload length, type.
    localparam int unsigned HDR_LEN  = 22;
    localparam int unsigned POS_W    = 5;
    localparam logic [POS_W-1:0] HDR_LAST   = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] HDR_PLEN   = POS_W'(2);
    localparam logic [7:0]       SR_MIME_HDR = 8'hD2;
    localparam logic [7:0]       MIME_TLEN   = 8'd19;
    localparam logic [15:0]      HDR_LEN_W   = 16'(HDR_LEN);
    localparam int unsigned FILL_W   = 11;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_READ      = 2'd1,
        KIND_FIELD_ON  = 2'd2,
        KIND_FIELD_OFF = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RD_OK    = 2'd0,
        RD_EMPTY = 2'd1,
        RD_LOST  = 2'd2
    } rd_status_t;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_HOLD    = 2'd1,
        MODE_PAYLOAD = 2'd2
    } msg_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_RESP
    } ctl_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic        first_of_message;
    } in_item_t;

    typedef struct packed {
        rd_status_t        read_status;
        logic [7:0]        read_data;
        logic [FILL_W-1:0] fill_level;
        logic [31:0]       bytes_received;
        logic [31:0]       overflow_total;
        logic [31:0]       records_decoded;
        logic [31:0]       field_losses;
        logic [31:0]       events_seen;
        logic              field_present;
    } out_item_t;

    // Request from the controller to the receive ring.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_byte;
    } ring_req_t;

    // Request from the controller to the header hold buffer.
    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_pos;
        logic [7:0]       wr_byte;
        logic [15:0]      msg_len;
        logic [POS_W-1:0] rd_idx;
    } hold_req_t;

    // Expected header byte at each position; the payload length byte is free.
    function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = SR_MIME_HDR;
            5'd1:    b = MIME_TLEN;
            5'd3:    b = 8'h61; // a
            5'd4:    b = 8'h70; // p
            5'd5:    b = 8'h70; // p
            5'd6:    b = 8'h6C; // l
            5'd7:    b = 8'h69; // i
            5'd8:    b = 8'h63; // c
            5'd9:    b = 8'h61; // a
            5'd10:   b = 8'h74; // t
            5'd11:   b = 8'h69; // i
            5'd12:   b = 8'h6F; // o
            5'd13:   b = 8'h6E; // n
            5'd14:   b = 8'h2F; // /
            5'd15:   b = 8'h78; // x
            5'd16:   b = 8'h2D; // -
            5'd17:   b = 8'h6D; // m
            5'd18:   b = 8'h6F; // o
            5'd19:   b = 8'h64; // d
            5'd20:   b = 8'h65; // e
            5'd21:   b = 8'h6D; // m
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/ndmr_ring.sv */
module ndmr_ring
    import ndmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ring_req_t                       req,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(RING_DEPTH+1)-1:0] count,
    output logic [7:0]                      rd_byte
);

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    logic [7:0]    mem [RING_DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    rd_byte_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(RING_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rd_byte = rd_byte_reg;
    assign do_push = req.push && !full;
    assign do_pop  = req.pop && !empty;

    // Pointer and fill bookkeeping; pushes and pops never share a cycle, and a push wins over a pop.
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wp_next  = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop) begin
            rp_next  = (rp_reg == AW'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Byte storage with a registered read port.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wp_reg] <= req.push_byte;
        end
        if (do_pop) begin
            rd_byte_reg <= mem[rp_reg];
        end
    end

endmodule

/* rtl/ndmr_hdr_hold.sv */
module ndmr_hdr_hold
    import ndmr_pkg::*;
(
    input  logic      aclk,
    input  hold_req_t req,
    output logic      hdr_ok,
    output logic [7:0] plen,
    output logic [7:0] rd_byte
);

    logic [7:0] hold_reg [HDR_LEN];
    logic       match_reg, match_next;
    logic [7:0] plen_reg;
    logic       byte_hit;
    logic [16:0] need_len;

    assign byte_hit = (req.wr_pos == HDR_PLEN) || (req.wr_byte == hdr_byte(req.wr_pos));

    // Running comparison against the fixed header, restarted at position zero.
    assign match_next = (req.wr_pos == '0) ? byte_hit : (match_reg && byte_hit);

    // The last header byte also checks that the payload fits in the message.
    assign need_len = 17'(HDR_LEN_W) + 17'(plen_reg);
    assign hdr_ok   = match_next && (need_len <= 17'(req.msg_len));
    assign plen     = plen_reg;
    assign rd_byte  = hold_reg[req.rd_idx];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            hold_reg[req.wr_pos] <= req.wr_byte;
            match_reg            <= match_next;
            if (req.wr_pos == HDR_PLEN) begin
                plen_reg <= req.wr_byte;
            end
        end
    end

endmodule

/* rtl/ndef_mime_rx_deframer_fifo.sv */
// Message byte: a header that fails to match is flushed from the hold buffer into the ring.
// Read request: registered ring memory read, then the result register once it is free.
// One request is in work at a time; a finished result may wait in the output register
// while the next non-read request is taken.
// Reset (aresetn, synchronous, active low) clears pointers, counters, mode and field flag;
// ring and header storage are not cleared and need no clearing pass.
module ndef_mime_rx_deframer_fifo
    import ndmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    ctl_state_t        state_reg, state_next;
    msg_mode_t         mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        rem_reg, rem_next;
    logic [POS_W-1:0]  flush_reg, flush_next;
    logic              field_reg, field_next;
    rd_status_t        status_reg, status_next;
    logic [31:0]       rx_reg, rx_next;
    logic [31:0]       ovf_reg, ovf_next;
    logic [31:0]       rec_reg, rec_next;
    logic [31:0]       loss_reg, loss_next;
    logic [31:0]       evt_reg, evt_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    ring_req_t         ring_req;
    logic              ring_full;
    logic              ring_empty;
    logic [CW-1:0]     ring_count;
    logic [7:0]        ring_rd_byte;
    hold_req_t         hold_req;
    logic              hdr_ok;
    logic [7:0]        hdr_plen;
    logic [7:0]        hold_rd_byte;

    logic              accept;
    msg_mode_t         eff_mode;
    logic [POS_W-1:0]  eff_pos;

    ndmr_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (ring_req),
        .full   (ring_full),
        .empty  (ring_empty),
        .count  (ring_count),
        .rd_byte(ring_rd_byte)
    );

    ndmr_hdr_hold u_hold (
        .aclk   (aclk),
        .req    (hold_req),
        .hdr_ok (hdr_ok),
        .plen   (hdr_plen),
        .rd_byte(hold_rd_byte)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A first-marked byte picks the mode and restarts the position.
    always_comb begin
        if (s_data.first_of_message) begin
            eff_mode = (s_data.message_length > HDR_LEN_W) ? MODE_HOLD : MODE_PASS;
            eff_pos  = '0;
        end else begin
            eff_mode = mode_reg;
            eff_pos  = pos_reg;
        end
    end

    // Controller: byte routing, header flush, read requests and statistics.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        flush_next   = flush_reg;
        field_next   = field_reg;
        status_next  = status_reg;
        rec_next     = rec_reg;
        loss_next    = loss_reg;
        evt_next     = evt_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        ring_req          = '0;
        hold_req          = '0;
        hold_req.wr_pos   = eff_pos;
        hold_req.wr_byte  = s_data.data_byte;
        hold_req.msg_len  = s_data.message_length;
        hold_req.rd_idx   = flush_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.kind)
                        KIND_BYTE: begin
                            mode_next = eff_mode;
                            pos_next  = eff_pos;
                            if (s_data.first_of_message) begin
                                evt_next = evt_reg + 1'b1;
                                rem_next = '0;
                            end
                            unique case (eff_mode)
                                MODE_HOLD: begin
                                    hold_req.wr_en = 1'b1;
                                    if (eff_pos == HDR_LAST) begin
                                        if (hdr_ok) begin
                                            rec_next  = rec_reg + 1'b1;
                                            mode_next = MODE_PAYLOAD;
                                            rem_next  = hdr_plen;
                                        end else begin
                                            mode_next  = MODE_PASS;
                                            flush_next = '0;
                                            state_next = ST_FLUSH;
                                        end
                                    end else begin
                                        pos_next = eff_pos + 1'b1;
                                    end
                                end
                                MODE_PAYLOAD: begin
                                    if (rem_reg != '0) begin
                                        ring_req.push      = 1'b1;
                                        ring_req.push_byte = s_data.data_byte;
                                        rem_next           = rem_reg - 1'b1;
                                    end
                                end
                                default: begin
                                    ring_req.push      = 1'b1;
                                    ring_req.push_byte = s_data.data_byte;
                                end
                            endcase
                        end
                        KIND_READ: begin
                            if (!field_reg) begin
                                status_next = RD_LOST;
                            end else if (!ring_empty) begin
                                ring_req.pop = 1'b1;
                                status_next  = RD_OK;
                            end else begin
                                status_next = RD_EMPTY;
                            end
                            state_next = ST_RESP;
                        end
                        KIND_FIELD_ON: begin
                            evt_next   = evt_reg + 1'b1;
                            field_next = 1'b1;
                        end
                        KIND_FIELD_OFF: begin
                            evt_next   = evt_reg + 1'b1;
                            field_next = 1'b0;
                            if (field_reg) begin
                                loss_next = loss_reg + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                // Push the held header bytes in order, one a cycle.
                ring_req.push      = 1'b1;
                ring_req.push_byte = hold_rd_byte;
                if (flush_reg == HDR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    flush_next = flush_reg + 1'b1;
                end
            end
            ST_RESP: begin
                // The ring read data is valid now; wait for a free output register.
                if (!m_valid_reg || m_ready) begin
                    out_next.read_status     = status_reg;
                    out_next.read_data       = (status_reg == RD_OK) ? ring_rd_byte : 8'h00;
                    out_next.fill_level      = FILL_W'(ring_count);
                    out_next.bytes_received  = rx_reg;
                    out_next.overflow_total  = ovf_reg;
                    out_next.records_decoded = rec_reg;
                    out_next.field_losses    = loss_reg;
                    out_next.events_seen     = evt_reg;
                    out_next.field_present   = field_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring acceptance and overflow counters follow every push.
    assign rx_next  = (ring_req.push && !ring_full) ? rx_reg + 1'b1 : rx_reg;
    assign ovf_next = (ring_req.push && ring_full) ? ovf_reg + 1'b1 : ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_PASS;
            pos_reg     <= '0;
            rem_reg     <= '0;
            flush_reg   <= '0;
            field_reg   <= 1'b0;
            status_reg  <= RD_OK;
            rx_reg      <= '0;
            ovf_reg     <= '0;
            rec_reg     <= '0;
            loss_reg    <= '0;
            evt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            flush_reg   <= flush_next;
            field_reg   <= field_next;
            status_reg  <= status_next;
            rx_reg      <= rx_next;
            ovf_reg     <= ovf_next;
            rec_reg     <= rec_next;
            loss_reg    <= loss_next;
            evt_reg     <= evt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule
